### hdl/tndm_pkg.sv
// ----------------------------------------------------------------------------
// tndm_pkg: shared constants and a saturating add for the descriptor match core
// Holds field widths, register indexes, opcodes and the reset threshold.
// ----------------------------------------------------------------------------
package tndm_pkg;
    localparam int unsigned MaxEntries   = 64;
    localparam int unsigned DescLen      = 128;
    localparam int unsigned DistW        = 41;
    localparam int unsigned ElemW        = 16;
    localparam int unsigned EntW         = 6;
    localparam int unsigned EidxW        = 7;
    localparam int unsigned UseW         = 7;
    localparam int unsigned CfgIdxW      = 1;
    localparam logic [DistW-1:0] ThreshReset = 41'd42949673;
    localparam logic [DistW-1:0] DistMax     = {DistW{1'b1}};

    localparam logic [CfgIdxW-1:0] RegThreshold = 1'b0;
    localparam logic [CfgIdxW-1:0] RegEntries   = 1'b1;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

    // Saturating accumulate of a squared difference.
    function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                                 input logic [32:0] b);
        logic [DistW:0] s;
        begin
            s = {1'b0, a} + {{(DistW-32){1'b0}}, b};
            sat_add = s[DistW] ? DistMax : s[DistW-1:0];
        end
    endfunction
endpackage

### hdl/tndm_cell.sv
// ----------------------------------------------------------------------------
// tndm_cell: one distance accumulator in the circulating chain
// Takes a distance from its neighbor, optionally adds a square or clears it, passes it on.
// ----------------------------------------------------------------------------
module tndm_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  logic                            i_add,
    input  logic                            i_clr,
    input  logic [32:0]                     i_sq,
    input  logic [tndm_pkg::DistW-1:0]      i_dist,
    output logic [tndm_pkg::DistW-1:0]      o_dist
);
    logic [tndm_pkg::DistW-1:0] r_dist;
    logic [tndm_pkg::DistW-1:0] n_dist;

    always_comb begin
        n_dist = r_dist;
        if (i_shift) begin
            n_dist = i_add ? tndm_pkg::sat_add(i_dist, i_sq) : i_dist;
            if (i_clr) begin
                n_dist = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
        end else begin
            r_dist <= n_dist;
        end
    end

    assign o_dist = r_dist;
endmodule

### hdl/thresholded_nearest_descriptor_match_core.sv
// ----------------------------------------------------------------------------
// thresholded_nearest_descriptor_match_core: nearest enrolled descriptor search
// Enrolled descriptors in a memory, running distances in a ring of cells.
// ----------------------------------------------------------------------------
// Load transactions write one enrolled element into an on-chip memory when
// accepted. A query transaction holds the input from its acceptance to the
// next acceptance: the running distances sit in a ring of MAX_ENTRIES cells
// that rotates one step a cycle, and each step the cell at the head of the
// ring adds the squared difference for one entry read from the memory's
// single read port, behind a read stage and a squaring stage. On the
// transaction marked tlast the same rotation compares each distance to the
// threshold, keeps the nearest (lowest index on ties) and clears the
// distances; the result then passes through the S_OUT and S_WAIT states
// into the output register. The master side holds one pending result while
// the next transaction is taken; a second result waits until the first one
// leaves, and the input stalls meanwhile. Entries at or above entries_in_use
// are not searched. The enrolled memory has no reset; reading a never-written
// element is outside the contract. There is no clearing pass.
module thresholded_nearest_descriptor_match_core #(
    parameter int unsigned MAX_ENTRIES = tndm_pkg::MaxEntries,
    parameter int unsigned DESC_LEN    = tndm_pkg::DescLen
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // s_axis_tdata fields from bit 0: entry_index[6], element_index[7],
    // element_value[16]; zero padded to 32 bits.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,
    // s_axis_tuser fields from bit 0: opcode.
    input  logic                        s_axis_tuser,
    input  logic                        s_axis_tlast,
    // m_axis_tdata fields from bit 0: matched, best_index[6]; padded to 8.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [tndm_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [tndm_pkg::DistW-1:0]  i_cfg_data
);
    localparam int unsigned EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned LW   = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
    localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned Depth = MAX_ENTRIES * DESC_LEN;
    localparam int unsigned DW   = tndm_pkg::DistW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_OUT  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    // Input field extraction.
    logic                           w_op;
    logic [tndm_pkg::EntW-1:0]      w_ent;
    logic [tndm_pkg::EidxW-1:0]     w_elem;
    logic signed [15:0]             w_val;
    logic                           w_acc;
    assign w_op   = s_axis_tuser;
    assign w_ent  = s_axis_tdata[5:0];
    assign w_elem = s_axis_tdata[12:6];
    assign w_val  = s_axis_tdata[28:13];
    assign w_acc  = s_axis_tvalid && s_axis_tready;

    // Configuration.
    logic [DW-1:0]                  r_thresh;
    logic [tndm_pkg::UseW-1:0]      r_use;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= tndm_pkg::ThreshReset;
            r_use    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tndm_pkg::RegThreshold: r_thresh <= i_cfg_data;
                tndm_pkg::RegEntries:   r_use <= i_cfg_data[tndm_pkg::UseW-1:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] w_nact;
    assign w_nact = ({25'd0, r_use} > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                        : CW'(r_use);

    // Enrolled memory.
    logic signed [15:0] r_mem [Depth];
    logic signed [15:0] r_rd;
    logic [$clog2(Depth)-1:0] w_rd_addr;

    logic w_load_ok;
    assign w_load_ok = ({26'd0, w_ent} < 32'(MAX_ENTRIES)) &&
                       ({25'd0, w_elem} < 32'(DESC_LEN));

    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == tndm_pkg::OpLoad && w_load_ok) begin
            r_mem[($clog2(Depth))'(w_ent) * ($clog2(Depth))'(DESC_LEN)
                  + ($clog2(Depth))'(w_elem)] <= w_val;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Sequencer.
    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt;        // read pointer / issue step
    logic [CW:0]    r_step;       // ring rotation counter
    logic [LW-1:0]  r_elem;
    logic           r_elem_ok, r_last;
    logic signed [15:0] r_val;
    logic           r_pv;         // read issued last cycle is valid
    logic [EW-1:0]  r_pidx;
    logic           r_pact;

    assign w_rd_addr = ($clog2(Depth))'(r_cnt[EW-1:0]) * ($clog2(Depth))'(DESC_LEN)
                       + ($clog2(Depth))'(r_elem);

    // Square of difference, registered ahead of the ring.
    logic signed [16:0] w_diff;
    logic [16:0]        w_abs;
    logic [32:0]        r_sq;
    logic               r_sv, r_sact;
    logic [EW-1:0]      r_sidx;
    assign w_diff = 17'(r_val) - 17'(r_rd);
    assign w_abs  = w_diff[16] ? 17'(-w_diff) : w_diff;

    // Ring of cells.
    logic [DW-1:0] w_ring [MAX_ENTRIES];
    logic          w_shift, w_add, w_clr;
    assign w_shift = r_sv;
    assign w_add   = r_sact && r_elem_ok;
    assign w_clr   = r_last;

    // Search over the values entering the head cell (after update).
    logic [DW-1:0] w_head_new;
    assign w_head_new = w_add ? tndm_pkg::sat_add(w_ring[MAX_ENTRIES-1], r_sq)
                              : w_ring[MAX_ENTRIES-1];

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            tndm_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(w_shift),
                .i_add  (g == 0 ? w_add : 1'b0),
                .i_clr  (g == 0 ? w_clr : 1'b0),
                .i_sq   (r_sq),
                .i_dist (g == 0 ? w_ring[MAX_ENTRIES-1] : w_ring[(g + MAX_ENTRIES - 1) % MAX_ENTRIES]),
                .o_dist (w_ring[g])
            );
        end
    endgenerate

    logic           r_found;
    logic [EW-1:0]  r_best;
    logic [DW-1:0]  r_bestd;
    logic           r_ovalid;
    logic [7:0]     r_odata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc && w_op == tndm_pkg::OpQuery) n_state = S_RUN;
            S_RUN:  if (r_step == (CW+1)'(MAX_ENTRIES) && !r_sv)
                        n_state = r_last ? S_OUT : S_IDLE;
            S_OUT:  n_state = S_WAIT;
            S_WAIT: if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_sv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_step   <= '0;
            r_last   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state <= n_state;
            // In S_WAIT the output register is refilled below instead.
            if (r_ovalid && m_axis_tready && r_state != S_WAIT) r_ovalid <= 1'b0;
            r_pv <= 1'b0;
            r_sv <= r_pv;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && w_op == tndm_pkg::OpQuery) begin
                        r_elem    <= LW'(w_elem);
                        r_elem_ok <= {25'd0, w_elem} < 32'(DESC_LEN);
                        r_val     <= w_val;
                        r_last    <= s_axis_tlast;
                        r_cnt     <= '0;
                        r_step    <= '0;
                        r_found   <= 1'b0;
                        r_bestd   <= '0;
                        r_best    <= '0;
                    end
                end
                S_RUN: begin
                    if (r_cnt != CW'(MAX_ENTRIES)) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_cnt[EW-1:0];
                        r_pact <= r_cnt < w_nact;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                    if (r_sv) begin
                        r_step <= r_step + 1'b1;
                        if (r_last && r_sact && w_head_new < r_thresh &&
                            (!r_found || w_head_new < r_bestd)) begin
                            r_found <= 1'b1;
                            r_best  <= r_sidx;
                            r_bestd <= w_head_new;
                        end
                    end
                end
                S_OUT: ;
                S_WAIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {1'b0, 6'(r_best & {EW{r_found}}), r_found};
                        r_last   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq   <= 33'(w_abs) * 33'(w_abs);
        r_sact <= r_pact;
        r_sidx <= r_pidx;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

### verif/thresholded_nearest_descriptor_match_core_test.sv
// ----------------------------------------------------------------------------
// thresholded_nearest_descriptor_match_core_test: self-checking bench
// Loads enrolled descriptors, streams query descriptors through the core and
// checks every match result against a predictor kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One predicted match result: the matched flag and the nearest entry.
typedef struct packed {
    logic       matched;
    logic [5:0] best_index;
} t_match_result;

// The scoreboard keeps its own copy of the enrolled table, the running
// distances and both registers, and predicts a result on each query
// transaction that carries tlast.
class t_match_scoreboard;
    logic signed [15:0]          enrolled [tndm_pkg::MaxEntries*tndm_pkg::DescLen];
    bit                          written  [tndm_pkg::MaxEntries*tndm_pkg::DescLen];
    logic [tndm_pkg::DistW-1:0]  running  [tndm_pkg::MaxEntries];
    logic [tndm_pkg::DistW-1:0]  threshold_sq;
    logic [tndm_pkg::UseW-1:0]   entries_in_use;
    t_match_result               expected_results [$];
    int                          errors;

    function new();
        threshold_sq   = tndm_pkg::ThreshReset;
        entries_in_use = '0;
        errors         = 0;
        foreach (running[i]) running[i] = '0;
        foreach (written[i]) written[i] = 1'b0;
        foreach (enrolled[i]) enrolled[i] = '0;
    endfunction

    function void write_reg(logic [tndm_pkg::CfgIdxW-1:0] idx,
                            logic [tndm_pkg::DistW-1:0] data);
        if (idx == tndm_pkg::RegThreshold) threshold_sq = data;
        else entries_in_use = data[tndm_pkg::UseW-1:0];
    endfunction

    // Entries searched by a query; values above the table size are clipped.
    function int searched();
        return (entries_in_use > tndm_pkg::MaxEntries) ? tndm_pkg::MaxEntries
                                                        : int'(entries_in_use);
    endfunction

    // True when every searched entry holds a written value at this element.
    function bit element_ready(int elem);
        for (int i = 0; i < searched(); i++)
            if (!written[i*tndm_pkg::DescLen + elem]) return 1'b0;
        return 1'b1;
    endfunction

    function void note_input(logic op, logic [5:0] ent, logic [6:0] elem,
                             logic signed [15:0] val, logic last);
        longint        diff;
        logic [41:0]   sum;
        bit            found;
        int            best;
        t_match_result res;
        found = 1'b0;
        best  = 0;
        if (op == tndm_pkg::OpLoad) begin
            enrolled[ent*tndm_pkg::DescLen + elem] = val;
            written[ent*tndm_pkg::DescLen + elem]  = 1'b1;
            return;
        end
        for (int i = 0; i < searched(); i++) begin
            diff = longint'(val) - longint'(enrolled[i*tndm_pkg::DescLen + elem]);
            sum  = {1'b0, running[i]} + 42'(diff * diff);
            running[i] = sum[41] ? tndm_pkg::DistMax : sum[40:0];
        end
        if (!last) return;
        // Strict threshold test; a later entry wins only when strictly nearer.
        for (int i = 0; i < searched(); i++) begin
            if (running[i] < threshold_sq && (!found || running[i] < running[best])) begin
                found = 1'b1;
                best  = i;
            end
        end
        res.matched    = found;
        res.best_index = found ? 6'(best) : 6'd0;
        expected_results.insert(expected_results.size(), res);
        foreach (running[i]) running[i] = '0;
    endfunction

    function void check_result(logic [7:0] data);
        t_match_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual matched=%0b best=%0d",
                     $time, data[0], data[6:1]);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (data[0] !== want.matched) begin
            $display("%0t: matched mismatch, expected %0b, actual %0b",
                     $time, want.matched, data[0]);
            errors++;
        end
        if (data[6:1] !== want.best_index) begin
            $display("%0t: best_index mismatch, expected %0d, actual %0d",
                     $time, want.best_index, data[6:1]);
            errors++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module thresholded_nearest_descriptor_match_core_test;
    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // Fields from bit 0: entry_index[6], element_index[7], element_value[16];
    // zero padded to 32 bits.
    logic [31:0]                      s_axis_tdata;
    // Fields from bit 0: opcode.
    logic                             s_axis_tuser;
    logic                             s_axis_tlast;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // Fields from bit 0: matched, best_index[6]; zero padded to 8 bits.
    logic [7:0]                       m_axis_tdata;
    logic                             i_cfg_we;
    logic [tndm_pkg::CfgIdxW-1:0]     i_cfg_idx;
    logic [tndm_pkg::DistW-1:0]       i_cfg_data;

    t_match_scoreboard scoreboard;
    // When set, both sides insert random idle bursts.
    bit idle_on;
    // Each increment asks the receiver for one long hold-off.
    int hold_requests;
    int items_sent;
    // Element positions that every entry has written, used for queries.
    int preloaded [4] = '{0, 127, 85, 42};

    thresholded_nearest_descriptor_match_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run, far beyond the slowest legal run.
    initial begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one transaction and returns at the edge where it is accepted.
    // tvalid stays high on return so back-to-back items need no toggle.
    task automatic send_item(logic op, logic [5:0] ent, logic [6:0] elem,
                             logic signed [15:0] val, logic last);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, elem, ent};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        scoreboard.note_input(op, ent, elem, val, last);
        items_sent++;
    endtask

    task automatic write_reg(logic [tndm_pkg::CfgIdxW-1:0] idx,
                             logic [tndm_pkg::DistW-1:0] data);
        s_axis_tvalid <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.write_reg(idx, data);
    endtask

    // Waits until every predicted result has arrived, then lets a full query
    // time pass so that no transaction without a result is still in flight.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (tndm_pkg::MaxEntries + 20) @(posedge i_clk);
    endtask

    // Picks an element whose searched entries are all written.
    function automatic int query_element();
        int elem;
        for (int k = 0; k < 8; k++) begin
            elem = $urandom_range(0, tndm_pkg::DescLen - 1);
            if (scoreboard.element_ready(elem)) return elem;
        end
        return preloaded[$urandom_range(0, 3)];
    endfunction

    // Streams one query descriptor of the given length. With copy_of set the
    // values follow one enrolled entry, with a small perturbation at times,
    // so that near and exact matches occur.
    task automatic send_query(int len, int copy_of);
        int                 elem;
        logic signed [15:0] val;
        for (int k = 0; k < len; k++) begin
            elem = query_element();
            if (copy_of >= 0) begin
                val = scoreboard.enrolled[copy_of*tndm_pkg::DescLen + elem];
                if ($urandom_range(0, 3) == 0) val = val + 16'($urandom_range(0, 6)) - 16'sd3;
            end else begin
                val = 16'($urandom);
            end
            send_item(tndm_pkg::OpQuery, 6'($urandom), 7'(elem), val, k == len - 1);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off per request.
    initial begin : receiver
        int stall_left;
        int hold_left;
        int holds_seen;
        stall_left = 0;
        hold_left  = 0;
        holds_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                scoreboard.check_result(m_axis_tdata);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [tndm_pkg::DistW-1:0] thr;
        logic signed [15:0]         val;
        int                         sel;
        scoreboard    = new();
        idle_on       = 1'b1;
        hold_requests = 0;
        items_sent    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers, no entries in use: the result is never a match.
        // A load with tlast set must not yield a result.
        send_item(tndm_pkg::OpLoad, 6'd0, 7'd0, -16'sd32768, 1'b1);
        send_item(tndm_pkg::OpQuery, 6'd63, 7'd127, 16'sd32767, 1'b1);

        // Enroll every entry at a few element positions, with the value
        // extremes on entry zero.
        for (int e = 0; e < tndm_pkg::MaxEntries; e++)
            for (int p = 0; p < 4; p++) begin
                val = (e == 0) ? ((p % 2) ? 16'sd32767 : -16'sd32768) : 16'($urandom);
                send_item(tndm_pkg::OpLoad, 6'(e), 7'(preloaded[p]), val, 1'($urandom));
            end
        drain();

        // Full table, widest threshold: the largest difference, a copy of one
        // entry, and an element sent twice.
        write_reg(tndm_pkg::RegEntries, 41'd64);
        write_reg(tndm_pkg::RegThreshold, tndm_pkg::DistMax);
        send_item(tndm_pkg::OpQuery, 6'd0, 7'd0, 16'sd32767, 1'b1);
        send_query(3, 5);
        send_item(tndm_pkg::OpQuery, 6'd0, 7'd42, 16'sd100, 1'b0);
        send_item(tndm_pkg::OpQuery, 6'd0, 7'd42, 16'sd100, 1'b1);
        drain();

        // Zero threshold never matches, even at distance zero; more entries
        // in use than the table holds searches the whole table.
        write_reg(tndm_pkg::RegThreshold, 41'd0);
        write_reg(tndm_pkg::RegEntries, 41'd127);
        send_query(2, 9);
        send_query(1, -1);
        drain();

        // Threshold of one: only an exact copy matches.
        write_reg(tndm_pkg::RegThreshold, 41'd1);
        write_reg(tndm_pkg::RegEntries, 41'd1);
        send_query(4, 0);
        send_query(4, -1);
        drain();

        // Random phases with a fresh setting each time.
        for (int phase = 0; items_sent < 450; phase++) begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: thr = tndm_pkg::DistMax;
                1: thr = 41'd0;
                2: thr = tndm_pkg::ThreshReset;
                3: thr = 41'({$urandom, $urandom});
                default: thr = 41'($urandom_range(0, 32'hFFFF_FFFF));
            endcase
            write_reg(tndm_pkg::RegThreshold, thr);
            write_reg(tndm_pkg::RegEntries,
                      41'($urandom_range(0, 127) % ((phase % 3 == 0) ? 128 : 65)));
            if (phase == 0) hold_requests++;
            for (int n = 0; n < 12; n++) begin
                // The last part of the run has no idling on either side.
                if (items_sent > 390) idle_on = 1'b0;
                if ($urandom_range(0, 9) < 3) begin
                    send_item(tndm_pkg::OpLoad, 6'($urandom), 7'($urandom), 16'($urandom),
                              1'($urandom));
                end else begin
                    send_query(($urandom_range(0, 19) == 0) ? tndm_pkg::DescLen
                                                            : $urandom_range(1, 6),
                               ($urandom_range(0, 1) == 0) ?
                               $urandom_range(0, tndm_pkg::MaxEntries - 1) : -1);
                end
            end
            drain();
        end

        if (scoreboard.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, scoreboard.pending());
            scoreboard.errors++;
        end
        if (scoreboard.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### sim.f
hdl/tndm_pkg.sv
hdl/tndm_cell.sv
hdl/thresholded_nearest_descriptor_match_core.sv
verif/thresholded_nearest_descriptor_match_core_test.sv
